// ----- hdl/vwvm_pkg.sv -----
// ----------------------------------------------------------------------------
// vwvm_pkg
// Shared constants and types for the vibration window variance monitor.
// ----------------------------------------------------------------------------
package vwvm_pkg;

	localparam int unsigned WINDOW_DEF = 200;
	localparam int unsigned ACC_W      = 24;
	localparam int unsigned DEV_W      = 24;
	localparam int unsigned VAR_W      = 32;
	localparam int unsigned GRAV_W     = 23;
	localparam int unsigned MINS_W     = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned QDEPTH     = 2;

	localparam logic [VAR_W-1:0]  THRESH_RST = 32'd32768;
	localparam logic [GRAV_W-1:0] GRAV_RST   = 23'd642908;
	localparam logic [MINS_W-1:0] MINS_RST   = 8'd100;

	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINS   = 2'd2;

	// item handed from front to back
	typedef struct packed {
		logic             is_report;
		logic [DEV_W-1:0] dev;
	} cmd_t;

endpackage

// ----- hdl/vibration_window_variance_monitor.sv -----
// ----------------------------------------------------------------------------
// vibration_window_variance_monitor
// Sliding-window variance of IMU acceleration deviation from gravity.
//
// channel | handshake           | payload
// in      | in_valid/in_ready   | req_type, acc_x, acc_y, acc_z
// out     | out_valid/out_ready | window_variance, enough_samples, vibration_alert
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample holds the front through the squaring of x, y and z and a 25-step
// square root; the back then reads the ring in B_RD and updates it in B_UPD.
// A report goes through B_MA, B_MB and B_SUB, then a restoring division of
// 2*24 + 2*clog2(WINDOW+1) + 1 steps, one quotient bit per step, to B_OUT.
// Reset clears counts and sums; the ring holds no reset value.
// The queue lets the front take the next request while the back stalls.
// ----------------------------------------------------------------------------
module vibration_window_variance_monitor #(
	parameter int unsigned WINDOW = vwvm_pkg::WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [vwvm_pkg::ACC_W-1:0]     acc_x,
	input  logic signed [vwvm_pkg::ACC_W-1:0]     acc_y,
	input  logic signed [vwvm_pkg::ACC_W-1:0]     acc_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [vwvm_pkg::VAR_W-1:0]            window_variance,
	output logic                                  enough_samples,
	output logic                                  vibration_alert,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vwvm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                           cfg_data
);
	logic [vwvm_pkg::VAR_W-1:0]  thresh_q;
	logic [vwvm_pkg::GRAV_W-1:0] grav_q;
	logic [vwvm_pkg::MINS_W-1:0] mins_q;
	logic                        fq_valid, fq_ready, qb_valid, qb_ready;
	vwvm_pkg::cmd_t              fq_cmd, qb_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= vwvm_pkg::THRESH_RST;
			grav_q   <= vwvm_pkg::GRAV_RST;
			mins_q   <= vwvm_pkg::MINS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				vwvm_pkg::REG_THRESH: thresh_q <= cfg_data;
				vwvm_pkg::REG_GRAV:   grav_q   <= cfg_data[vwvm_pkg::GRAV_W-1:0];
				vwvm_pkg::REG_MINS:   mins_q   <= cfg_data[vwvm_pkg::MINS_W-1:0];
				default: ;
			endcase
		end
	end

	vwvm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.grav(grav_q),
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	vwvm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
	);

	vwvm_back #(.WINDOW(WINDOW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.thresh(thresh_q), .min_samples(mins_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.window_variance(window_variance),
		.enough_samples(enough_samples),
		.vibration_alert(vibration_alert)
	);
endmodule

// ----- hdl/vwvm_front.sv -----
// ----------------------------------------------------------------------------
// vwvm_front
// Takes requests, forms |norm - gravity| of samples by a bit-serial root.
// ----------------------------------------------------------------------------
module vwvm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic signed [vwvm_pkg::ACC_W-1:0] acc_x,
	input  logic signed [vwvm_pkg::ACC_W-1:0] acc_y,
	input  logic signed [vwvm_pkg::ACC_W-1:0] acc_z,
	input  logic [vwvm_pkg::GRAV_W-1:0]     grav,
	output logic                            cmd_valid,
	input  logic                            cmd_ready,
	output vwvm_pkg::cmd_t                  cmd
);
	typedef enum logic [2:0] {F_IDLE, F_SQX, F_SQY, F_SQZ, F_ROOT, F_OUT} fst_t;

	fst_t        st_q;
	logic [23:0] mx_q, my_q, mz_q;
	logic [49:0] v_q;
	logic [49:0] r_q;
	logic [49:0] b_q;
	logic [4:0]  cnt_q;
	logic [47:0] sq;
	logic [23:0] sq_in;
	logic [49:0] rb;
	logic [24:0] dev_w;

	function automatic logic [23:0] mag(input logic [23:0] a);
		mag = a[23] ? (24'd0 - a) : a;
	endfunction

	always_comb begin
		case (st_q)
			F_SQX:   sq_in = mx_q;
			F_SQY:   sq_in = my_q;
			default: sq_in = mz_q;
		endcase
		sq    = sq_in * sq_in;
		rb    = r_q + b_q;
		dev_w = (r_q[24:0] >= {2'd0, grav}) ? r_q[24:0] - {2'd0, grav} :
			{2'd0, grav} - r_q[24:0];
	end

	assign in_ready = (st_q == F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= F_IDLE;
			cmd_valid <= 1'b0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						if (req_type) begin
							cmd.is_report <= 1'b1;
							cmd.dev       <= '0;
							cmd_valid     <= 1'b1;
							st_q          <= F_OUT;
						end else begin
							mx_q <= mag(acc_x);
							my_q <= mag(acc_y);
							mz_q <= mag(acc_z);
							v_q  <= '0;
							st_q <= F_SQX;
						end
					end
				end
				F_SQX: begin
					v_q  <= v_q + {2'd0, sq};
					st_q <= F_SQY;
				end
				F_SQY: begin
					v_q  <= v_q + {2'd0, sq};
					st_q <= F_SQZ;
				end
				F_SQZ: begin
					v_q   <= v_q + {2'd0, sq};
					r_q   <= '0;
					b_q   <= 50'd1 << 48;
					cnt_q <= 5'd25;
					st_q  <= F_ROOT;
				end
				F_ROOT: begin
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + b_q;
					end else begin
						r_q <= r_q >> 1;
					end
					b_q   <= b_q >> 2;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						st_q <= F_OUT;
					end
				end
				F_OUT: begin
					if (!cmd_valid) begin
						cmd.is_report <= 1'b0;
						cmd.dev       <= dev_w[23:0];
						cmd_valid     <= 1'b1;
					end else if (cmd_ready) begin
						cmd_valid <= 1'b0;
						st_q      <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/vwvm_queue.sv -----
// ----------------------------------------------------------------------------
// vwvm_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module vwvm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  vwvm_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output vwvm_pkg::cmd_t rd_data
);
	localparam int unsigned D = vwvm_pkg::QDEPTH;

	vwvm_pkg::cmd_t          mem_q [D];
	logic [$clog2(D)-1:0]    wp_q, rp_q;
	logic [$clog2(D+1)-1:0]  cnt_q;
	logic                    wr, rd;

	assign wr_ready = (cnt_q != D[$clog2(D+1)-1:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end
endmodule

// ----- hdl/vwvm_back.sv -----
// ----------------------------------------------------------------------------
// vwvm_back
// Window ring, running sums and serial variance division.
// ----------------------------------------------------------------------------
module vwvm_back #(
	parameter int unsigned WINDOW = vwvm_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  vwvm_pkg::cmd_t                cmd,
	input  logic [vwvm_pkg::VAR_W-1:0]    thresh,
	input  logic [vwvm_pkg::MINS_W-1:0]   min_samples,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vwvm_pkg::VAR_W-1:0]    window_variance,
	output logic                          enough_samples,
	output logic                          vibration_alert
);
	localparam int unsigned AW   = $clog2(WINDOW);
	localparam int unsigned CW   = $clog2(WINDOW + 1);
	localparam int unsigned SW   = vwvm_pkg::DEV_W + CW;
	localparam int unsigned QW   = 2 * vwvm_pkg::DEV_W + CW;
	localparam int unsigned NW   = QW + CW + 1;
	localparam int unsigned DW   = 2 * CW + 16;
	localparam int unsigned RW   = DW + 1;
	localparam int unsigned NB   = NW;
	localparam int unsigned KW   = $clog2(NB + 1);

	typedef enum logic [3:0] {
		B_IDLE, B_RD, B_UPD, B_MA, B_MB, B_SUB, B_DIV, B_OUT
	} bst_t;

	bst_t                    st_q;
	logic [vwvm_pkg::DEV_W-1:0] ring_q [WINDOW];
	logic [vwvm_pkg::DEV_W-1:0] old_q;
	logic [AW-1:0]           slot_q;
	logic [CW-1:0]           count_q;
	logic [SW-1:0]           sum_q;
	logic [QW-1:0]           sq_q;
	logic [vwvm_pkg::DEV_W-1:0] dev_q;
	logic [NW-1:0]           a_q, b_q, num_q;
	logic [DW-1:0]           den_q;
	logic [RW-1:0]           rem_q;
	logic                    big_q;
	logic [KW-1:0]           k_q;
	logic [RW-1:0]           rs;
	logic                    full;
	logic [2*vwvm_pkg::DEV_W-1:0] old_sqr, dev_sqr;
	logic [NW-1:0]           nsq, ssq;
	logic [DW-1:0]           nn;

	assign full      = (count_q == WINDOW[CW-1:0]);
	assign cmd_ready = (st_q == B_IDLE);
	assign rs        = {rem_q[RW-2:0], num_q[NW-1]};
	assign old_sqr   = old_q * old_q;
	assign dev_sqr   = dev_q * dev_q;
	assign nsq       = count_q * sq_q;
	assign ssq       = sum_q * sum_q;
	assign nn        = count_q * count_q;

	always_ff @(posedge clk) begin
		if (st_q == B_RD) begin
			old_q <= ring_q[slot_q];
		end
		if (st_q == B_UPD) begin
			ring_q[slot_q] <= dev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			slot_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (cmd_valid) begin
						dev_q <= cmd.dev;
						if (cmd.is_report) begin
							enough_samples <= (32'(count_q) >= 32'(min_samples));
							if (count_q == '0) begin
								window_variance <= '0;
								st_q            <= B_OUT;
							end else begin
								st_q <= B_MA;
							end
						end else begin
							st_q <= B_RD;
						end
					end
				end
				B_RD: st_q <= B_UPD;
				B_UPD: begin
					if (full) begin
						sum_q <= sum_q - SW'(old_q) + SW'(dev_q);
						sq_q  <= sq_q - QW'(old_sqr) + QW'(dev_sqr);
					end else begin
						sum_q   <= sum_q + SW'(dev_q);
						sq_q    <= sq_q + QW'(dev_sqr);
						count_q <= count_q + 1'b1;
					end
					slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					st_q   <= B_IDLE;
				end
				B_MA: begin
					a_q   <= nsq;
					den_q <= nn << 16;
					st_q  <= B_MB;
				end
				B_MB: begin
					b_q  <= ssq;
					st_q <= B_SUB;
				end
				B_SUB: begin
					if (a_q <= b_q) begin
						window_variance <= '0;
						k_q             <= '1;
						st_q            <= B_OUT;
					end else begin
						num_q <= a_q - b_q;
						rem_q <= '0;
						big_q <= 1'b0;
						k_q   <= KW'(NB);
						st_q  <= B_DIV;
					end
				end
				B_DIV: begin
					if (rs >= RW'(den_q)) begin
						rem_q <= rs - RW'(den_q);
						if (k_q > KW'(32)) begin
							big_q <= 1'b1;
						end
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rs;
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					k_q <= k_q - 1'b1;
					if (k_q == KW'(1)) begin
						st_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!out_valid) begin
						if (count_q != '0 && k_q == '0) begin
							window_variance <= big_q ? '1 : num_q[31:0];
						end
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						st_q      <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign vibration_alert = enough_samples && (window_variance > thresh);
endmodule

// ----- test/vibration_window_variance_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// vibration_window_variance_monitor_tb
// Checks every report of the variance monitor against a cycle-free model of
// the deviation window. Requests and register writes come in phases at several
// threshold, gravity and sample-count settings. The sender and the receiver
// both pause at random, and one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module vibration_window_variance_monitor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WIN = vwvm_pkg::WINDOW_DEF;
	localparam logic [vwvm_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct {
		logic                              report;
		logic signed [vwvm_pkg::ACC_W-1:0] ax;
		logic signed [vwvm_pkg::ACC_W-1:0] ay;
		logic signed [vwvm_pkg::ACC_W-1:0] az;
	} request_t;

	typedef struct {
		logic [vwvm_pkg::VAR_W-1:0] variance;
		logic                       enough;
		logic                       alert;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic signed [vwvm_pkg::ACC_W-1:0] acc_x = '0;
	logic signed [vwvm_pkg::ACC_W-1:0] acc_y = '0;
	logic signed [vwvm_pkg::ACC_W-1:0] acc_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [vwvm_pkg::VAR_W-1:0] window_variance;
	logic enough_samples;
	logic vibration_alert;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vwvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	request_t pending_requests[$];
	report_t  expected_reports[$];
	int errors = 0;

	// model of the block's registers and window
	logic [vwvm_pkg::VAR_W-1:0]  m_thresh = vwvm_pkg::THRESH_RST;
	logic [vwvm_pkg::GRAV_W-1:0] m_grav   = vwvm_pkg::GRAV_RST;
	logic [vwvm_pkg::MINS_W-1:0] m_mins   = vwvm_pkg::MINS_RST;
	logic [vwvm_pkg::DEV_W-1:0]  dev_ring[WIN];
	int unsigned       wr_slot = 0;
	int unsigned       n_stored = 0;
	logic [63:0]       dev_sum = '0;
	logic [63:0]       dev_sq_sum = '0;

	logic in_fire = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	logic hold_go = 1'b0;
	logic hold_used = 1'b0;
	logic burst = 1'b0;

	vibration_window_variance_monitor DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [63:0] abs24(input logic signed [vwvm_pkg::ACC_W-1:0] v);
		logic [vwvm_pkg::ACC_W-1:0] u;
		u = v[vwvm_pkg::ACC_W-1] ? vwvm_pkg::ACC_W'(0 - v) : v;
		return 64'(u);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void push_deviation(input request_t rq);
		logic [63:0] x, y, z, norm, g, dev, old;
		x = abs24(rq.ax);
		y = abs24(rq.ay);
		z = abs24(rq.az);
		norm = int_sqrt(x * x + y * y + z * z);
		g = 64'(m_grav);
		dev = (norm >= g) ? norm - g : g - norm;
		dev &= 64'hFF_FFFF;
		if (n_stored >= WIN) begin
			old = 64'(dev_ring[wr_slot]);
			dev_sum -= old;
			dev_sq_sum -= old * old;
		end else begin
			n_stored++;
		end
		dev_ring[wr_slot] = dev[vwvm_pkg::DEV_W-1:0];
		dev_sum += dev;
		dev_sq_sum += dev * dev;
		wr_slot = (wr_slot + 1 >= WIN) ? 0 : wr_slot + 1;
	endfunction

	function automatic report_t window_report();
		report_t r;
		logic [127:0] a, b, q, den;
		r.variance = '0;
		if (n_stored != 0) begin
			a = 128'(n_stored) * 128'(dev_sq_sum);
			b = 128'(dev_sum) * 128'(dev_sum);
			if (a > b) begin
				den = (128'(n_stored) * 128'(n_stored)) << 16;
				q = (a - b) / den;
				r.variance = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			end
		end
		r.enough = (n_stored >= int'(m_mins));
		r.alert = r.enough && (r.variance > m_thresh);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// acceptance, prediction, register model
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready && arst_n;
		if (arst_n && in_valid && in_ready) begin
			if (req_type) expected_reports.insert(expected_reports.size(), window_report());
			else push_deviation('{req_type, acc_x, acc_y, acc_z});
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				vwvm_pkg::REG_THRESH: m_thresh <= cfg_data[vwvm_pkg::VAR_W-1:0];
				vwvm_pkg::REG_GRAV:   m_grav <= cfg_data[vwvm_pkg::GRAV_W-1:0];
				vwvm_pkg::REG_MINS:   m_mins <= cfg_data[vwvm_pkg::MINS_W-1:0];
				default: ;
			endcase
		end
	end

	// request driver
	always @(negedge clk) begin
		request_t rq;
		if (in_valid && !in_fire) begin
			in_valid <= 1'b1;
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			rq = pending_requests[0];
			pending_requests.delete(0);
			req_type <= rq.report;
			acc_x <= rq.ax;
			acc_y <= rq.ay;
			acc_z <= rq.az;
			in_valid <= 1'b1;
			gap_left <= burst ? 0 : pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_left <= 600;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_left > 0 || (hold_go && !hold_used)) begin
			out_ready <= 1'b0;
		end else if (burst) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (r < 6) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(10, 50);
		end else begin
			out_ready <= (r >= 30);
		end
	end

	// report checker
	always @(posedge clk) begin
		report_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected report var=%h", window_variance));
			end else begin
				e = expected_reports[0];
				expected_reports.delete(0);
				if (window_variance !== e.variance)
					report_mismatch($sformatf("variance %h, expected %h",
						window_variance, e.variance));
				if (enough_samples !== e.enough)
					report_mismatch($sformatf("enough_samples %b, expected %b",
						enough_samples, e.enough));
				if (vibration_alert !== e.alert)
					report_mismatch($sformatf("vibration_alert %b, expected %b",
						vibration_alert, e.alert));
			end
		end
	end

	task automatic add_request(input logic rep, input int x, input int y, input int z);
		request_t rq;
		rq = '{rep, vwvm_pkg::ACC_W'(x), vwvm_pkg::ACC_W'(y), vwvm_pkg::ACC_W'(z)};
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	task automatic add_random(input int count, input int report_pct);
		int g;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < report_pct) begin
				add_request(1'b1, $urandom, $urandom, $urandom);
			end else if ($urandom_range(0, 9) < 7) begin
				g = int'(m_grav) + $urandom_range(0, 400000) - 200000;
				if ($urandom_range(0, 1)) g = -g;
				add_request(1'b0, $urandom_range(0, 40000) - 20000,
					$urandom_range(0, 40000) - 20000, g);
			end else begin
				add_request(1'b0, $urandom, $urandom, $urandom);
			end
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vwvm_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty window, field extremes, report with payload set
		add_request(1'b1, -8388608, 8388607, -1);
		add_request(1'b0, 0, 0, 0);
		add_request(1'b1, 0, 0, 0);
		add_request(1'b0, -8388608, -8388608, -8388608);
		add_request(1'b0, 8388607, 8388607, 8388607);
		add_request(1'b0, -8388608, 0, 0);
		add_request(1'b0, 0, 8388607, 0);
		add_request(1'b0, 0, 0, 642908);
		add_request(1'b0, 0, 0, -642908);
		add_request(1'b0, -1, -1, -1);
		add_request(1'b1, 0, 0, 0);
		add_request(1'b0, 1, 0, 0);
		add_request(1'b1, 8388607, -8388608, 0);
		drain();

		// gravity zero, alert at any spread, one sample enough
		write_reg(vwvm_pkg::REG_THRESH, 32'h0);
		write_reg(vwvm_pkg::REG_GRAV, 32'h0);
		write_reg(vwvm_pkg::REG_MINS, 32'hFFFF_FF01);
		add_random(120, 20);
		drain();

		// top values, window fills and wraps
		write_reg(vwvm_pkg::REG_THRESH, 32'hFFFF_FFFF);
		write_reg(vwvm_pkg::REG_GRAV, 32'hFFFF_FFFF);
		write_reg(vwvm_pkg::REG_MINS, 32'd200);
		write_reg(REG_NONE, $urandom);
		burst = 1'b1;
		add_random(120, 15);
		drain();
		burst = 1'b0;

		// zero minimum, back-pressure while reports pile up
		write_reg(vwvm_pkg::REG_THRESH, $urandom_range(0, 2000000));
		write_reg(vwvm_pkg::REG_GRAV, 32'd642908);
		write_reg(vwvm_pkg::REG_MINS, 32'd0);
		hold_go = 1'b1;
		add_random(90, 50);
		drain();

		// minimum beyond the window
		write_reg(vwvm_pkg::REG_THRESH, $urandom_range(0, 200000));
		write_reg(vwvm_pkg::REG_MINS, 32'd255);
		add_random(60, 25);
		drain();

		write_reg(vwvm_pkg::REG_MINS, $urandom_range(1, 200));
		add_random(60, 25);
		drain();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
